FILE: src/cau_pkg.sv
// cau_pkg: payload types and command codes for the complex arithmetic unit
// no dependencies
package cau_pkg;
   localparam int unsigned DW = 16;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type              cmd;
      logic signed [DW-1:0] a_re;
      logic signed [DW-1:0] a_im;
      logic signed [DW-1:0] b_re;
      logic signed [DW-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] res_re;
      logic signed [DW-1:0] res_im;
      logic                 overflow;
      logic                 div_by_zero;
   } rsp_type;
endpackage

FILE: src/cau_fifo.sv
// cau_fifo: small queue between the front and back parts
// depends on cau_pkg
module cau_fifo import cau_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  req_type wr_data,
   output logic    rd_valid,
   input  logic    rd_ready,
   output req_type rd_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   req_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic wr, rd;

   assign wr_ready = (cnt_ff != (AW+1)'(DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_comb begin
      wp_in  = wr ? ((wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in  = rd ? ((rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (wr) mem_ff[wp_ff] <= wr_data;
   end
endmodule

FILE: src/cau_back.sv
// cau_back: pipelined datapath (multiply stage, combine stage, divider stages, output)
// depends on cau_pkg
module cau_back import cau_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);
   // magnitude widths: products up to 2^30, sums 2^31, dividend shifted by FRAC
   localparam int PW = 2*DW;
   localparam int NW = PW + FRAC_BITS;           // dividend width
   localparam int QW = NW;                        // quotient width
   localparam int NS = NW;                        // one quotient bit per stage
   localparam logic [QW-1:0] MAGCAP = QW'(1) << (DW-1);
   localparam logic signed [DW-1:0] MAXPOS = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] MINNEG = {1'b1, {(DW-1){1'b0}}};

   // the pipeline advances as a whole when the output register can take data
   logic adv;
   logic out_valid_ff;
   assign adv      = !out_valid_ff || out_ready;
   assign in_ready = adv;

   // stage 1: products
   logic               s1_v_ff;
   cmd_type            s1_cmd_ff;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff, p_bb_ff;
   logic signed [DW:0] s1_sum_re_ff, s1_sum_im_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (adv) s1_v_ff <= in_valid;
      if (adv) begin
         s1_cmd_ff <= in_data.cmd;
         p_rr_ff <= in_data.a_re * in_data.b_re;
         p_ii_ff <= in_data.a_im * in_data.b_im;
         p_ir_ff <= in_data.a_im * in_data.b_re;
         p_ri_ff <= in_data.a_re * in_data.b_im;
         p_bb_ff <= in_data.b_im * in_data.b_im;
         if (in_data.cmd == CMD_SUB) begin
            s1_sum_re_ff <= (DW+1)'(in_data.a_re) - (DW+1)'(in_data.b_re);
            s1_sum_im_ff <= (DW+1)'(in_data.a_im) - (DW+1)'(in_data.b_im);
         end else begin
            s1_sum_re_ff <= (DW+1)'(in_data.a_re) + (DW+1)'(in_data.b_re);
            s1_sum_im_ff <= (DW+1)'(in_data.a_im) + (DW+1)'(in_data.b_im);
         end
      end
   end
   // b_re^2 computed alongside from the same stage
   logic signed [PW-1:0] p_br2_ff;
   always_ff @(posedge clock) begin
      if (adv) p_br2_ff <= in_data.b_re * in_data.b_re;
   end

   // stage 2: combine products into numerators and denominator
   logic               s2_v_ff;
   cmd_type            s2_cmd_ff;
   logic signed [PW:0] num_re_ff, num_im_ff;
   logic [PW-1:0]      den_ff;
   logic signed [DW:0] s2_sum_re_ff, s2_sum_im_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (adv) s2_v_ff <= s1_v_ff;
      if (adv) begin
         s2_cmd_ff <= s1_cmd_ff;
         s2_sum_re_ff <= s1_sum_re_ff;
         s2_sum_im_ff <= s1_sum_im_ff;
         den_ff <= PW'(p_br2_ff) + PW'(p_bb_ff);
         if (s1_cmd_ff == CMD_DIV) begin
            num_re_ff <= (PW+1)'(p_rr_ff) + (PW+1)'(p_ii_ff);
            num_im_ff <= (PW+1)'(p_ir_ff) - (PW+1)'(p_ri_ff);
         end else begin
            num_re_ff <= (PW+1)'(p_rr_ff) - (PW+1)'(p_ii_ff);
            num_im_ff <= (PW+1)'(p_ir_ff) + (PW+1)'(p_ri_ff);
         end
      end
   end

   // divider pipeline: restoring division, one quotient bit per stage, both parts
   typedef struct packed {
      logic               v;
      cmd_type            cmd;
      logic               neg_re;
      logic               neg_im;
      logic [NW-1:0]      n_re;   // remaining dividend bits, shifted left
      logic [NW-1:0]      n_im;
      logic [PW:0]        r_re;   // partial remainder
      logic [PW:0]        r_im;
      logic [QW-1:0]      q_re;
      logic [QW-1:0]      q_im;
      logic [PW-1:0]      den;
      logic signed [DW:0] sum_re;
      logic signed [DW:0] sum_im;
      logic signed [PW:0] num_re;
      logic signed [PW:0] num_im;
   } dstage_type;

   dstage_type ds_ff [NS+1];
   dstage_type ds_in [NS+1];

   always_comb begin
      ds_in[0].v      = s2_v_ff;
      ds_in[0].cmd    = s2_cmd_ff;
      ds_in[0].neg_re = num_re_ff[PW];
      ds_in[0].neg_im = num_im_ff[PW];
      ds_in[0].n_re   = {(num_re_ff[PW] ? PW'(-num_re_ff) : PW'(num_re_ff)),
                         {FRAC_BITS{1'b0}}};
      ds_in[0].n_im   = {(num_im_ff[PW] ? PW'(-num_im_ff) : PW'(num_im_ff)),
                         {FRAC_BITS{1'b0}}};
      ds_in[0].r_re   = '0;
      ds_in[0].r_im   = '0;
      ds_in[0].q_re   = '0;
      ds_in[0].q_im   = '0;
      ds_in[0].den    = den_ff;
      ds_in[0].sum_re = s2_sum_re_ff;
      ds_in[0].sum_im = s2_sum_im_ff;
      ds_in[0].num_re = num_re_ff;
      ds_in[0].num_im = num_im_ff;
   end

   for (genvar k = 0; k < NS; k++) begin : g_div
      logic [PW:0] tr_re, tr_im;
      always_comb begin
         ds_in[k+1] = ds_ff[k];
         tr_re = {ds_ff[k].r_re[PW-1:0], ds_ff[k].n_re[NW-1]};
         tr_im = {ds_ff[k].r_im[PW-1:0], ds_ff[k].n_im[NW-1]};
         ds_in[k+1].n_re = ds_ff[k].n_re << 1;
         ds_in[k+1].n_im = ds_ff[k].n_im << 1;
         if (tr_re >= {1'b0, ds_ff[k].den}) begin
            ds_in[k+1].r_re = tr_re - {1'b0, ds_ff[k].den};
            ds_in[k+1].q_re = {ds_ff[k].q_re[QW-2:0], 1'b1};
         end else begin
            ds_in[k+1].r_re = tr_re;
            ds_in[k+1].q_re = {ds_ff[k].q_re[QW-2:0], 1'b0};
         end
         if (tr_im >= {1'b0, ds_ff[k].den}) begin
            ds_in[k+1].r_im = tr_im - {1'b0, ds_ff[k].den};
            ds_in[k+1].q_im = {ds_ff[k].q_im[QW-2:0], 1'b1};
         end else begin
            ds_in[k+1].r_im = tr_im;
            ds_in[k+1].q_im = {ds_ff[k].q_im[QW-2:0], 1'b0};
         end
      end
   end

   for (genvar k = 0; k <= NS; k++) begin : g_dreg
      always_ff @(posedge clock) begin
         if (reset) ds_ff[k].v <= 1'b0;
         else if (adv) ds_ff[k].v <= ds_in[k].v;
         if (adv) begin
            ds_ff[k].cmd    <= ds_in[k].cmd;
            ds_ff[k].neg_re <= ds_in[k].neg_re;
            ds_ff[k].neg_im <= ds_in[k].neg_im;
            ds_ff[k].n_re   <= ds_in[k].n_re;
            ds_ff[k].n_im   <= ds_in[k].n_im;
            ds_ff[k].r_re   <= ds_in[k].r_re;
            ds_ff[k].r_im   <= ds_in[k].r_im;
            ds_ff[k].q_re   <= ds_in[k].q_re;
            ds_ff[k].q_im   <= ds_in[k].q_im;
            ds_ff[k].den    <= ds_in[k].den;
            ds_ff[k].sum_re <= ds_in[k].sum_re;
            ds_ff[k].sum_im <= ds_in[k].sum_im;
            ds_ff[k].num_re <= ds_in[k].num_re;
            ds_ff[k].num_im <= ds_in[k].num_im;
         end
      end
   end

   // final stage: saturate and select
   dstage_type f;
   assign f = ds_ff[NS];

   function automatic logic signed [DW-1:0] sat_add(input logic signed [DW:0] v,
                                                    output logic ovf);
      ovf = 1'b0;
      sat_add = v[DW-1:0];
      if (v[DW] != v[DW-1]) begin
         ovf = 1'b1;
         sat_add = v[DW] ? MINNEG : MAXPOS;
      end
   endfunction

   function automatic logic signed [DW-1:0] sat_mul(input logic signed [PW:0] v,
                                                    output logic ovf);
      logic signed [PW:0] s;
      s = v >>> FRAC_BITS;
      ovf = 1'b0;
      sat_mul = s[DW-1:0];
      if (s > (PW+1)'(MAXPOS)) begin
         ovf = 1'b1;
         sat_mul = MAXPOS;
      end else if (s < (PW+1)'(MINNEG)) begin
         ovf = 1'b1;
         sat_mul = MINNEG;
      end
   endfunction

   function automatic logic signed [DW-1:0] sat_div(input logic neg,
                                                    input logic [QW-1:0] q,
                                                    output logic ovf);
      ovf = 1'b0;
      if (!neg) begin
         sat_div = q[DW-1:0];
         if (q > MAGCAP - 1'b1) begin
            ovf = 1'b1;
            sat_div = MAXPOS;
         end
      end else begin
         sat_div = DW'(-q);
         if (q > MAGCAP) begin
            ovf = 1'b1;
            sat_div = MINNEG;
         end
      end
   endfunction

   rsp_type out_ff, out_in;
   always_comb begin
      logic o1, o2;
      out_in = '0;
      o1 = 1'b0;
      o2 = 1'b0;
      case (f.cmd)
         CMD_ADD, CMD_SUB: begin
            out_in.res_re = sat_add(f.sum_re, o1);
            out_in.res_im = sat_add(f.sum_im, o2);
         end
         CMD_MUL: begin
            out_in.res_re = sat_mul(f.num_re, o1);
            out_in.res_im = sat_mul(f.num_im, o2);
         end
         CMD_DIV: begin
            if (f.den == '0) begin
               out_in.div_by_zero = 1'b1;
            end else begin
               out_in.res_re = sat_div(f.neg_re, f.q_re, o1);
               out_in.res_im = sat_div(f.neg_im, f.q_im, o2);
            end
         end
         default: ;
      endcase
      out_in.overflow = o1 | o2;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (adv) out_valid_ff <= f.v;
      if (adv) out_ff <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   a_dz_only_div: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_data.div_by_zero |-> !out_data.overflow)
      else $error("div_by_zero with overflow");
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_data.div_by_zero |-> out_data.res_re == '0 && out_data.res_im == '0)
      else $error("div_by_zero result not zero");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_data))
      else $error("output register changed while stalled");
endmodule

FILE: src/complex_arith_unit.sv
// complex_arith_unit: top level, front queue plus pipelined complex datapath
// depends on cau_pkg, cau_fifo, cau_back
//
// complex-number alu on signed q8.8 operands: add, subtract, multiply and
// divide, one result transaction per request transaction, saturating with an
// overflow flag and a div_by_zero flag (zero result) for a zero divisor. the
// front queue accepts requests whenever it has room; the back pipeline takes
// one transaction per cycle unless stalled: one product stage, one combine
// stage, a divider load register, one restoring-divider stage per quotient
// bit (2*16+FRAC_BITS = 40 stages) and an output register; every command
// runs through all of them. the pipeline moves as a whole, sustaining one
// transaction per clock, and stalls only while the output register is held.
module complex_arith_unit import cau_pkg::*; #(
   parameter int FRAC_BITS  = 8,
   parameter int FIFO_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   logic    q_valid, q_ready;
   req_type q_data;

   // front: queue decouples the requester from the pipeline stall
   cau_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_valid),
      .wr_ready (req_ready),
      .wr_data  (req_data),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_data)
   );

   // back: arithmetic pipeline
   cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_data   (q_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );
endmodule
